/* rtl/core/gait_pattern_generator_defines.svh */
// ----------------------------------------------------------------------------
// gait_pattern_generator_defines
// assertion macros for the gait pattern generator top level
// ----------------------------------------------------------------------------
`ifndef GAIT_PATTERN_GENERATOR_DEFINES_SVH
`define GAIT_PATTERN_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, switched off while reset is held
`define GPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs through reset
`define GPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPG_ASSERT(label, prop, msg)
`define GPG_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/core/gpg_pkg.sv */
// ----------------------------------------------------------------------------
// gpg_pkg
// types, constants, coefficient tables and microcode for the gait generator
// ----------------------------------------------------------------------------
package gpg_pkg;

  // sine lookup resolution and polynomial coefficients, q.14
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_DROP       = 16 - SINE_TABLE_BITS;
  localparam int SIN_A           = 25736;
  localparam int SIN_B           = 10538;
  localparam int SIN_C           = 1186;

  // datapath widths
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // motor numbering
  localparam logic [3:0] LAST_BODY  = 4'd5;
  localparam logic [3:0] FIRST_LEG  = 4'd6;
  localparam logic [3:0] LAST_MOTOR = 4'd9;

  // configuration register indexes
  localparam logic [2:0] REG_PHASE_STEP = 3'd0;
  localparam logic [2:0] REG_WALK_GAIN  = 3'd1;
  localparam logic [2:0] REG_SWIM_GAIN  = 3'd2;
  localparam logic [2:0] REG_WALK_ENTER = 3'd3;
  localparam logic [2:0] REG_SWIM_ENTER = 3'd4;

  typedef struct packed {
    logic        [15:0] phase_step;
    logic        [12:0] walk_gain;
    logic        [12:0] swim_gain;
    logic signed [15:0] walk_enter_level;
    logic signed [15:0] swim_enter_level;
  } cfg_t;

  // control word fields
  typedef enum logic [2:0] {
    MUL_NONE, MUL_GK, MUL_TT, MUL_T2C, MUL_T2R, MUL_TR, MUL_GKS
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_STATE, WB_ANGLE, WB_GK, WB_T2, WB_R1, WB_R2, WB_S, WB_BODY, WB_LEG
  } wb_op_t;

  typedef enum logic [2:0] {
    BR_NEXT, BR_GOTO, BR_WAIT_IN, BR_LOOP_BODY, BR_LOOP_LEG
  } br_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_CLR, CNT_INC
  } cnt_op_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    mul_op_t mul;
    wb_op_t  wb;
    logic    emit;
    br_op_t  br;
    cnt_op_t cnt;
    pc_t     target;
  } uword_t;

  // program addresses
  localparam pc_t S_IDLE      = 4'd0;
  localparam pc_t S_UPD       = 4'd1;
  localparam pc_t S_ANGLE     = 4'd2;
  localparam pc_t S_MUL_TT    = 4'd3;
  localparam pc_t S_T2        = 4'd4;
  localparam pc_t S_MUL_T2C   = 4'd5;
  localparam pc_t S_R1        = 4'd6;
  localparam pc_t S_MUL_T2R   = 4'd7;
  localparam pc_t S_R2        = 4'd8;
  localparam pc_t S_MUL_TR    = 4'd9;
  localparam pc_t S_SINE      = 4'd10;
  localparam pc_t S_MUL_GKS   = 4'd11;
  localparam pc_t S_BODY      = 4'd12;
  localparam pc_t S_BODY_LOOP = 4'd13;
  localparam pc_t S_LEG       = 4'd14;
  localparam pc_t S_DONE      = 4'd15;

  localparam uword_t UW_NOP = '{mul: MUL_NONE, wb: WB_NONE, emit: 1'b0,
                                br: BR_NEXT, cnt: CNT_HOLD, target: S_IDLE};

  function automatic uword_t uw(mul_op_t m, wb_op_t w, logic e, br_op_t b,
                                cnt_op_t c, pc_t t);
    uword_t r;
    r = '{mul: m, wb: w, emit: e, br: b, cnt: c, target: t};
    return r;
  endfunction

  // program rom: one control word per step
  function automatic uword_t ucode(pc_t pc);
    uword_t r;
    unique case (pc)
      S_IDLE:      r = uw(MUL_NONE, WB_NONE,  1'b0, BR_WAIT_IN,   CNT_HOLD, S_IDLE);
      S_UPD:       r = uw(MUL_NONE, WB_STATE, 1'b0, BR_NEXT,      CNT_CLR,  S_IDLE);
      S_ANGLE:     r = uw(MUL_GK,   WB_ANGLE, 1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_MUL_TT:    r = uw(MUL_TT,   WB_GK,    1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_T2:        r = uw(MUL_NONE, WB_T2,    1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_MUL_T2C:   r = uw(MUL_T2C,  WB_NONE,  1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_R1:        r = uw(MUL_NONE, WB_R1,    1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_MUL_T2R:   r = uw(MUL_T2R,  WB_NONE,  1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_R2:        r = uw(MUL_NONE, WB_R2,    1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_MUL_TR:    r = uw(MUL_TR,   WB_NONE,  1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_SINE:      r = uw(MUL_NONE, WB_S,     1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_MUL_GKS:   r = uw(MUL_GKS,  WB_NONE,  1'b0, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_BODY:      r = uw(MUL_NONE, WB_BODY,  1'b1, BR_NEXT,      CNT_HOLD, S_IDLE);
      S_BODY_LOOP: r = uw(MUL_NONE, WB_NONE,  1'b0, BR_LOOP_BODY, CNT_INC,  S_ANGLE);
      S_LEG:       r = uw(MUL_NONE, WB_LEG,   1'b1, BR_LOOP_LEG,  CNT_INC,  S_LEG);
      S_DONE:      r = uw(MUL_NONE, WB_NONE,  1'b0, BR_GOTO,      CNT_HOLD, S_IDLE);
      default:     r = UW_NOP;
    endcase
    return r;
  endfunction

  // walking body coefficients, q.12
  function automatic logic signed [15:0] walk_coef(logic [2:0] i);
    logic signed [15:0] c;
    unique case (i)
      3'd0:    c = -16'sd2867;
      3'd1:    c = 16'sd4096;
      3'd2:    c = 16'sd4096;
      3'd3:    c = 16'sd0;
      3'd4:    c = -16'sd4096;
      3'd5:    c = -16'sd4096;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

  // swimming phase lag per segment, 2^-16 turn
  function automatic logic [15:0] swim_step(logic [2:0] i);
    logic [15:0] s;
    unique case (i)
      3'd0:    s = 16'd0;
      3'd1:    s = 16'd10923;
      3'd2:    s = 16'd21845;
      3'd3:    s = 16'd32768;
      3'd4:    s = 16'd43691;
      3'd5:    s = 16'd54613;
      default: s = 16'd0;
    endcase
    return s;
  endfunction

  // swimming amplitude growth toward the tail, q.12
  function automatic logic signed [15:0] swim_taper(logic [2:0] i);
    logic signed [15:0] f;
    unique case (i)
      3'd0:    f = 16'sd2048;
      3'd1:    f = 16'sd2458;
      3'd2:    f = 16'sd2867;
      3'd3:    f = 16'sd3277;
      3'd4:    f = 16'sd3686;
      3'd5:    f = 16'sd4096;
      default: f = 16'sd0;
    endcase
    return f;
  endfunction

endpackage

/* rtl/core/gpg_datapath.sv */
// ----------------------------------------------------------------------------
// gpg_datapath
// gait state, shared multiplier and sine polynomial registers, driven by the
// control word of the sequencer
// ----------------------------------------------------------------------------
module gpg_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  gpg_pkg::uword_t     ctrl,
  input  logic [3:0]          mot,
  input  gpg_pkg::cfg_t       cfg,
  input  logic signed [15:0]  elevation,
  input  logic signed [13:0]  steering_offset,
  output logic signed [31:0]  position,
  output logic                gait_is_swim
);
  import gpg_pkg::*;

  // architectural state
  logic [31:0] phase_r;
  logic        mode_r;
  logic [31:0] leg_r [4];

  // polynomial and product registers
  logic [14:0]               t_r;
  logic                      neg_r;
  logic [14:0]               t2_r;
  logic [14:0]               r_r;
  logic signed [15:0]        s_r;
  logic signed [MUL_A_W-1:0] gk_r;
  logic signed [PROD_W-1:0]  prod_r;

  // tick update
  logic [31:0] ph1, ph2, half, base;
  logic [15:0] base_hi;
  logic        leave, enter, inc, mode_nxt;

  always_comb begin
    ph1      = phase_r - {16'd0, cfg.phase_step};
    leave    = mode_r && ($signed(elevation) > $signed(cfg.walk_enter_level));
    enter    = !mode_r && ($signed(elevation) < $signed(cfg.swim_enter_level));
    // whole turn toward zero, then back a quarter turn
    inc      = ph1[31] && (ph1[15:0] != 16'd0);
    base_hi  = ph1[31:16] + {15'd0, inc} - 16'd1;
    base     = {base_hi, 16'hC000};
    ph2      = leave ? leg_r[0] : ph1;
    half     = ph2 + 32'h0000_8000;
    mode_nxt = (mode_r && !leave) || enter;
  end

  // sine argument fold to a quarter turn
  logic [15:0] ang, xq, y, t_full;

  always_comb begin
    ang    = phase_r[15:0] + (mode_r ? swim_step(mot[2:0]) : 16'd0);
    xq     = {ang[15:SINE_DROP], {SINE_DROP{1'b0}}};
    y      = {1'b0, xq[14:0]};
    t_full = (y > 16'd16384) ? (16'd32768 - y) : y;
  end

  // shared multiplier operand selection
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_GK: begin
        mul_a = $signed({14'd0, (mode_r ? cfg.swim_gain : cfg.walk_gain)});
        mul_b = mode_r ? swim_taper(mot[2:0]) : walk_coef(mot[2:0]);
      end
      MUL_TT: begin
        mul_a = $signed({12'd0, t_r});
        mul_b = $signed({1'b0, t_r});
      end
      MUL_T2C: begin
        mul_a = $signed({12'd0, t2_r});
        mul_b = MUL_B_W'(SIN_C);
      end
      MUL_T2R: begin
        mul_a = $signed({12'd0, t2_r});
        mul_b = $signed({1'b0, r_r});
      end
      MUL_TR: begin
        mul_a = $signed({12'd0, t_r});
        mul_b = $signed({1'b0, r_r});
      end
      MUL_GKS: begin
        mul_a = gk_r;
        mul_b = s_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // q.14 rounding of non-negative polynomial products
  logic [30:0] r14_sum;
  logic [15:0] p14;
  logic [14:0] s_mag;

  always_comb begin
    r14_sum = {1'b0, prod_r[29:0]} + 31'd8192;
    p14     = r14_sum[29:14];
    s_mag   = (p14 > 16'd16384) ? 15'd16384 : p14[14:0];
  end

  // body set-point: q.38 to q.12, ties away from zero, plus steering
  logic signed [PROD_W-1:0] body_sum;
  logic signed [17:0]       body_val;

  always_comb begin
    body_sum = prod_r + (prod_r[PROD_W-1] ? PROD_W'(33554431) : PROD_W'(33554432));
    body_val = 18'($signed(body_sum[PROD_W-1:26])) + 18'(steering_offset);
  end

  // result selection
  logic [3:0] leg_off;

  always_comb begin
    leg_off = mot - FIRST_LEG;
    if (ctrl.wb == WB_LEG) begin
      position = leg_r[leg_off[1:0]];
    end else begin
      position = 32'(body_val);
    end
  end

  assign gait_is_swim = mode_r;

  // gait state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      mode_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        leg_r[i] <= '0;
      end
    end else if (ctrl.wb == WB_STATE) begin
      phase_r <= ph2;
      mode_r  <= mode_nxt;
      if (!mode_nxt) begin
        leg_r[0] <= ph2;
        leg_r[1] <= half;
        leg_r[2] <= half;
        leg_r[3] <= ph2;
      end else if (enter) begin
        for (int i = 0; i < 4; i++) begin
          leg_r[i] <= base;
        end
      end
    end
  end

  // working registers, written as the control word selects
  always_ff @(posedge clk) begin
    if (ctrl.mul != MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    unique case (ctrl.wb)
      WB_ANGLE: begin
        t_r   <= t_full[14:0];
        neg_r <= xq[15];
      end
      WB_GK:   gk_r <= prod_r[MUL_A_W-1:0];
      WB_T2:   t2_r <= p14[14:0];
      WB_R1:   r_r  <= 15'(SIN_B) - p14[14:0];
      WB_R2:   r_r  <= 15'(SIN_A) - p14[14:0];
      WB_S:    s_r  <= neg_r ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/gait_pattern_generator.sv */
// ----------------------------------------------------------------------------
// gait_pattern_generator
// walk / swim gait generator: per tick, ten motor set-points from a
// microcoded sequencer over a shared multiplier datapath
// ----------------------------------------------------------------------------
//  channel  direction  ports                                         transfer
//  in       input      in_elevation, in_steering_offset              valid & !stall
//  out      output     out_motor_index, out_position,                valid & !stall
//                      out_gait_is_swim, out_last
//  cfg      input      cfg_index, cfg_data                           cfg_we
//
//  from input transfer to the next possible one, a tick runs the accept and
//  the state update, a pass per body motor (the sine polynomial and gain
//  products run one after another through the single multiplier), a step
//  per leg and a return step.
//  reset loads the register defaults and clears phase, gait and legs; no
//  clearing pass. an output stall holds the emitting step until the result
//  register drains. input is taken only at the idle step.
// ----------------------------------------------------------------------------
`include "gait_pattern_generator_defines.svh"

module gait_pattern_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_elevation,
  input  logic signed [13:0] in_steering_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_motor_index,
  output logic signed [31:0] out_position,
  output logic               out_gait_is_swim,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gpg_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step       <= 16'd2936;
      cfg_r.walk_gain        <= 13'd2458;
      cfg_r.swim_gain        <= 13'd4096;
      cfg_r.walk_enter_level <= 16'sd170;
      cfg_r.swim_enter_level <= 16'sd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP: cfg_r.phase_step       <= cfg_data;
        REG_WALK_GAIN:  cfg_r.walk_gain        <= cfg_data[12:0];
        REG_SWIM_GAIN:  cfg_r.swim_gain        <= cfg_data[12:0];
        REG_WALK_ENTER: cfg_r.walk_enter_level <= $signed(cfg_data);
        REG_SWIM_ENTER: cfg_r.swim_enter_level <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // sequencer
  pc_t        pc_r, pc_nxt;
  logic [3:0] mot_r, mot_nxt;
  uword_t     uw_cur, ctrl;
  logic       in_accept, hold, emit_fire;

  assign in_stall  = (pc_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    uw_cur    = ucode(pc_r);
    hold      = uw_cur.emit && out_valid && out_stall;
    ctrl      = hold ? UW_NOP : uw_cur;
    emit_fire = uw_cur.emit && !hold;

    pc_nxt = pc_r;
    if (!hold) begin
      unique case (uw_cur.br)
        BR_NEXT:      pc_nxt = pc_r + pc_t'(1);
        BR_GOTO:      pc_nxt = uw_cur.target;
        BR_WAIT_IN:   pc_nxt = in_accept ? pc_r + pc_t'(1) : pc_r;
        BR_LOOP_BODY: pc_nxt = (mot_r != LAST_BODY) ? uw_cur.target : pc_r + pc_t'(1);
        BR_LOOP_LEG:  pc_nxt = (mot_r != LAST_MOTOR) ? uw_cur.target : pc_r + pc_t'(1);
        default:      pc_nxt = S_IDLE;
      endcase
    end

    unique case (ctrl.cnt)
      CNT_HOLD: mot_nxt = mot_r;
      CNT_CLR:  mot_nxt = 4'd0;
      CNT_INC:  mot_nxt = mot_r + 4'd1;
      default:  mot_nxt = mot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= S_IDLE;
      mot_r <= 4'd0;
    end else begin
      pc_r  <= pc_nxt;
      mot_r <= mot_nxt;
    end
  end

  // input capture on transfer
  logic signed [15:0] elev_r;
  logic signed [13:0] steer_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      elev_r  <= in_elevation;
      steer_r <= in_steering_offset;
    end
  end

  // datapath
  logic signed [31:0] dp_position;
  logic               dp_swim;

  gpg_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .mot             (mot_r),
    .cfg             (cfg_r),
    .elevation       (elev_r),
    .steering_offset (steer_r),
    .position        (dp_position),
    .gait_is_swim    (dp_swim)
  );

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_motor_index  <= mot_r;
      out_position     <= dp_position;
      out_gait_is_swim <= dp_swim;
      out_last         <= (mot_r == LAST_MOTOR);
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `GPG_ASSERT_ALWAYS(a_reset_drains, !rst_n |=> !out_valid, "result valid after reset")
  `GPG_ASSERT(a_accept_updates, in_accept |=> (pc_r == S_UPD), "transfer not followed by update")
  `GPG_ASSERT(a_last_index, (out_valid && out_last) |-> (out_motor_index == LAST_MOTOR), "last flag on wrong motor")
  `GPG_ASSERT(a_index_range, out_valid |-> (out_motor_index <= LAST_MOTOR), "motor index out of range")

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the walk / swim gait generator: a shadow copy of
// the phase, gait and leg state predicts the ten set-points of every tick,
// and each output transfer is checked in order against them. directed ticks
// cover the gait switches and field extremes, random ticks follow under
// several register settings, most with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpg_pkg::*;

  localparam int NUM_BODY     = 6;
  localparam int MOTOR_COUNT  = 10;
  localparam int TABLE_DROP   = 16 - SINE_TABLE_BITS;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;
  // about 180 ticks with heavy stalling, many times over
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct {
    logic [3:0]         motor;
    logic signed [31:0] position;
    logic               swim;
    logic               is_last;
  } setpoint_t;

  // shadow of the block state, predicts the set-points of each tick
  class gait_shadow;
    localparam longint POLY_A = 25736;
    localparam longint POLY_B = 10538;
    localparam longint POLY_C = 1186;
    localparam longint WALK_SHAPE [NUM_BODY] = '{-2867, 4096, 4096, 0, -4096, -4096};
    localparam logic [31:0] SWIM_LAG [NUM_BODY] =
      '{32'd0, 32'd10923, 32'd21845, 32'd32768, 32'd43691, 32'd54613};
    localparam longint SWIM_TAIL_GAIN [NUM_BODY] = '{2048, 2458, 2867, 3277, 3686, 4096};

    logic [15:0]        phase_step;
    logic [12:0]        walk_gain;
    logic [12:0]        swim_gain;
    logic signed [15:0] walk_enter_level;
    logic signed [15:0] swim_enter_level;

    logic [31:0]        phase;
    logic               swimming;
    logic [31:0]        leg_angle [4];

    setpoint_t          due_setpoints [$];
    int                 mismatches;

    function new();
      phase_step       = 16'd2936;
      walk_gain        = 13'd2458;
      swim_gain        = 13'd4096;
      walk_enter_level = 16'sd170;
      swim_enter_level = 16'sd50;
      phase            = '0;
      swimming         = 1'b0;
      foreach (leg_angle[i]) leg_angle[i] = '0;
      mismatches       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_PHASE_STEP: phase_step       = data;
        REG_WALK_GAIN:  walk_gain        = data[12:0];
        REG_SWIM_GAIN:  swim_gain        = data[12:0];
        REG_WALK_ENTER: walk_enter_level = data;
        REG_SWIM_ENTER: swim_enter_level = data;
        default: ;
      endcase
    endfunction

    // q.14 sine of the low 16 bits, cut to the table resolution
    function int sine_q14(logic [31:0] angle);
      longint unsigned x, y, t, t2, r, s;
      x = angle[15:0];
      x = (x >> TABLE_DROP) << TABLE_DROP;
      y = x & 64'h7FFF;
      t = (y > 16384) ? 32768 - y : y;
      t2 = (t * t + 8192) >> 14;
      r = (t2 * POLY_C + 8192) >> 14;
      r = POLY_B - r;
      r = (t2 * r + 8192) >> 14;
      r = POLY_A - r;
      s = (t * r + 8192) >> 14;
      if (s > 16384) s = 16384;
      return x[15] ? -int'(s) : int'(s);
    endfunction

    // q.38 product down to q.12, ties away from zero
    function longint to_q12(longint p);
      longint mag;
      mag = (p < 0) ? -p : p;
      mag = (mag + (64'sd1 <<< 25)) >>> 26;
      return (p < 0) ? -mag : mag;
    endfunction

    function void advance_tick(logic signed [15:0] elev, logic signed [13:0] steer);
      longint      body [NUM_BODY];
      logic [31:0] base;
      int          s;
      setpoint_t   sp;
      phase = phase - {16'h0, phase_step};
      // gait switch with hysteresis, only the test for the current gait
      if (swimming && elev > walk_enter_level) begin
        swimming = 1'b0;
        phase = leg_angle[0];
      end else if (!swimming && elev < swim_enter_level) begin
        base = {phase[31:16], 16'h0};
        swimming = 1'b1;
        if (phase[31] && phase[15:0] != 16'h0) base += 32'h10000;
        base -= 32'd16384;
        foreach (leg_angle[i]) leg_angle[i] = base;
      end
      // body set-points and leg rotation
      if (!swimming) begin
        s = sine_q14(phase);
        for (int i = 0; i < NUM_BODY; i++)
          body[i] = to_q12(longint'(walk_gain) * WALK_SHAPE[i] * s) + longint'(steer);
        leg_angle[0] = phase;
        leg_angle[1] = phase + 32'd32768;
        leg_angle[2] = phase + 32'd32768;
        leg_angle[3] = phase;
      end else begin
        for (int i = 0; i < NUM_BODY; i++) begin
          s = sine_q14(phase + SWIM_LAG[i]);
          body[i] = to_q12(longint'(swim_gain) * SWIM_TAIL_GAIN[i] * s) + longint'(steer);
        end
      end
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        sp.motor    = i[3:0];
        sp.position = (i < NUM_BODY) ? body[i][31:0] : leg_angle[i - NUM_BODY];
        sp.swim     = swimming;
        sp.is_last  = (i == MOTOR_COUNT - 1);
        due_setpoints.push_back(sp);
      end
    endfunction

    function void check_setpoint(setpoint_t got);
      setpoint_t want;
      if (due_setpoints.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected set-point transfer: motor %0d pos %0d swim %0b last %0b",
                   got.motor, got.position, got.swim, got.is_last);
        return;
      end
      want = due_setpoints.pop_front();
      if (got.motor !== want.motor || got.position !== want.position ||
          got.swim !== want.swim || got.is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("set-point mismatch: exp motor %0d pos %0d swim %0b last %0b, got motor %0d pos %0d swim %0b last %0b",
                   want.motor, want.position, want.swim, want.is_last,
                   got.motor, got.position, got.swim, got.is_last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_elevation = '0;
  logic signed [13:0] in_steering_offset = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_motor_index;
  logic signed [31:0] out_position;
  logic               out_gait_is_swim;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  gait_shadow shadow = new();
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         cycle_count = 0;
  int         bias_kind = 0;
  int         bias_left = 0;

  gait_pattern_generator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_elevation       (in_elevation),
    .in_steering_offset (in_steering_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_index    (out_motor_index),
    .out_position       (out_position),
    .out_gait_is_swim   (out_gait_is_swim),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // result transfer check
  always @(posedge clk) begin
    setpoint_t got;
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      got.motor    = out_motor_index;
      got.position = out_position;
      got.swim     = out_gait_is_swim;
      got.is_last  = out_last;
      shadow.check_setpoint(got);
    end
  end

  function automatic int idle_gap();
    int n = 0;
    while (n < 40 && $urandom_range(99) < tx_idle_pct) n++;
    return n;
  endfunction

  // elevation in runs biased to one side of the levels so both gaits last a while
  function automatic logic signed [15:0] pick_elevation();
    int                 v;
    logic signed [15:0] raw;
    if (bias_left == 0) begin
      bias_kind = $urandom_range(3);
      bias_left = $urandom_range(1, 6);
    end
    bias_left--;
    case (bias_kind)
      0: v = int'(shadow.walk_enter_level) + int'($urandom_range(1, 300));
      1: v = int'(shadow.swim_enter_level) - int'($urandom_range(1, 300));
      2: v = $urandom_range(1) ? int'(shadow.walk_enter_level)
                               : int'(shadow.swim_enter_level);
      default: begin
        raw = 16'($urandom);
        v = int'(raw);
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // one tick on the input channel; called and left at a falling edge
  task automatic send_tick(input logic signed [15:0] elev, input logic signed [13:0] steer);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_elevation       = elev;
    in_steering_offset = steer;
    in_valid           = 1'b1;
    do @(posedge clk); while (in_stall);
    shadow.advance_tick(elev, steer);
    @(negedge clk);
  endtask

  task automatic send_random_tick();
    logic signed [13:0] steer;
    if ($urandom_range(9) == 0)
      steer = $urandom_range(1) ? 14'sh1FFF : 14'sh2000;
    else
      steer = 14'($urandom);
    send_tick(pick_elevation(), steer);
  endtask

  // wait for every outstanding set-point, then let the sequencer return to idle
  task automatic settle();
    in_valid = 1'b0;
    while (shadow.due_setpoints.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    shadow.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setting(input int p);
    logic signed [15:0] walk_lvl;
    logic signed [15:0] swim_lvl;
    case (p)
      0: begin
        write_reg(REG_PHASE_STEP, 16'hFFFF);
        write_reg(REG_WALK_GAIN, 16'h1FFF);
        write_reg(REG_SWIM_GAIN, 16'h1FFF);
        write_reg(REG_WALK_ENTER, 16'h8000);
        write_reg(REG_SWIM_ENTER, 16'h7FFF);
      end
      1: begin
        write_reg(REG_PHASE_STEP, 16'h0);
        write_reg(REG_WALK_GAIN, 16'h0);
        write_reg(REG_SWIM_GAIN, 16'h0);
        write_reg(REG_WALK_ENTER, 16'h0);
        write_reg(REG_SWIM_ENTER, 16'h0);
      end
      2: begin
        // levels at the far ends: the gait never changes
        write_reg(REG_PHASE_STEP, 16'h4000);
        write_reg(REG_WALK_GAIN, 16'($urandom));
        write_reg(REG_SWIM_GAIN, 16'($urandom));
        write_reg(REG_WALK_ENTER, 16'h7FFF);
        write_reg(REG_SWIM_ENTER, 16'h8000);
      end
      default: begin
        walk_lvl = 16'(int'($urandom_range(6000)) - 3000);
        if ($urandom_range(3) == 0)
          swim_lvl = 16'(int'(walk_lvl) + int'($urandom_range(1, 600)));
        else
          swim_lvl = 16'(int'(walk_lvl) - int'($urandom_range(600)));
        write_reg(REG_PHASE_STEP, 16'($urandom));
        write_reg(REG_WALK_GAIN, 16'($urandom));
        write_reg(REG_SWIM_GAIN, 16'($urandom));
        write_reg(REG_WALK_ENTER, walk_lvl);
        write_reg(REG_SWIM_ENTER, swim_lvl);
      end
    endcase
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    tx_idle_pct = 19;
    rx_idle_pct = 46;

    // half-turn steps: swim entry from a negative whole turn, then from a
    // negative phase with a fraction that rounds toward zero
    write_reg(REG_PHASE_STEP, 16'h8000);
    send_tick(16'sd32767, 14'sd8191);
    send_tick(16'sd0, 14'sh2000);
    send_tick(16'sd32767, 14'sd0);
    send_tick(16'sd49, 14'sd100);
    settle();

    // default levels: equal values hold the gait, one past them switches
    write_reg(REG_PHASE_STEP, 16'd2936);
    for (int i = REG_SWIM_ENTER + 1; i < 8; i++) write_reg(i[2:0], 16'($urandom));
    send_tick(16'sd32767, 14'sh2000);
    send_tick(16'sd50, 14'sd0);
    send_tick(16'sd49, 14'sd1);
    send_tick(16'sd170, -14'sd1);
    send_tick(16'sd171, 14'sd4095);
    send_tick(16'sh8000, 14'sh2000);
    send_tick(16'sd32767, 14'sd8191);
    send_tick(-16'sd1, -14'sd1);
    send_tick(16'sd1000, 14'sd0);
    settle();

    // crossed levels toggle once per tick; gain data wider than the registers
    write_reg(REG_WALK_ENTER, -16'sd100);
    write_reg(REG_SWIM_ENTER, 16'sd100);
    write_reg(REG_WALK_GAIN, 16'hFFFF);
    write_reg(REG_SWIM_GAIN, 16'hFFFF);
    send_tick(16'sd0, 14'sd8191);
    send_tick(16'sd0, 14'sh2000);
    send_tick(16'sd0, 14'sd0);
    send_tick(16'sd200, 14'sd0);

    // random ticks under eight settings, idling pattern changes across them
    for (int p = 0; p < 8; p++) begin
      settle();
      if (p < 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 46;
      end else if (p < 6) begin
        tx_idle_pct = 46;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      load_setting(p);
      for (int k = 0; k < 20; k++) begin
        // occasionally hold off until the block has fully drained
        if ($urandom_range(19) == 0) settle();
        send_random_tick();
      end
    end
    settle();

    if (shadow.mismatches == 0 && shadow.due_setpoints.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
